// File: hw/rtl/ckc_pkg.sv
package ckc_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FracBitsDef  = 12;
  localparam int unsigned SumBits      = 36;
  localparam int unsigned CntBits      = 25;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 13;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegTol   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegRefB  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegRefG  = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegRefR  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegWidth = 3'd4;

  localparam logic [11:0] TolReset   = 12'd819;
  localparam logic [12:0] RefBReset  = 13'd1198;
  localparam logic [12:0] RefGReset  = 13'd1615;
  localparam logic [12:0] RefRReset  = 13'd3568;
  localparam logic [12:0] WidthReset = 13'd640;

  typedef struct packed {
    logic [7:0] pix_blue;
    logic [7:0] pix_green;
    logic [7:0] pix_red;
    logic       end_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic        pixel_matched;
    logic        frame_done;
    logic [15:0] centroid_col;
    logic [15:0] centroid_row;
    logic [24:0] match_count;
    logic        no_match;
  } res_out_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkWork,
    BkDiv,
    BkOut
  } bk_state_e;

endpackage

// File: hw/rtl/ckc_front.sv
// Front: takes a pixel, computes Q.4 norm (bit-serial root), then per-channel
// quotients (shared restoring divider), then the colour match flag.
module ckc_front #(
  parameter int unsigned FracBits = ckc_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  ckc_pkg::pix_in_t    data_i,
  input  logic [11:0]         tol_i,
  input  logic [12:0]         ref_b_i,
  input  logic [12:0]         ref_g_i,
  input  logic [12:0]         ref_r_i,
  output logic                valid_o,
  input  logic                stall_i,
  output ckc_pkg::pix_in_t    data_o,
  output logic                hit_o
);
  import ckc_pkg::*;

  localparam int unsigned NumBits = FracBits + 12;   // dividend width
  localparam int unsigned StepBits = $clog2(NumBits + 1);
  localparam int unsigned DenBits = 14;

  typedef enum logic [2:0] {FIdle, FSqrt, FDiv, FDist, FDone} f_state_e;

  f_state_e            st_q, st_d;
  pix_in_t             pix_q;
  logic [25:0]         rem_q, rem_d;
  logic [12:0]         root_q, root_d;
  logic [4:0]          sqi_q, sqi_d;
  logic [1:0]          ch_q, ch_d;
  logic [StepBits-1:0] dvi_q, dvi_d;
  logic [NumBits-1:0]  quo_q, quo_d;
  logic [DenBits:0]    drem_q, drem_d;
  logic [NumBits-1:0]  nb_q, ng_q, nr_q;
  logic [DenBits-1:0]  den;
  logic [NumBits-1:0]  dividend;
  logic [7:0]          chv;
  logic [16:0]         s_blue, s_green, s_red;
  logic [17:0]         sq_sum;
  logic [25:0]         sq_in;
  logic [27:0]         trial;
  logic [DenBits:0]    dshift;
  logic [NumBits:0]    db, dg, dr;
  logic [2*NumBits+3:0] dist_sum;
  logic                hit_q;

  assign s_blue  = {9'd0, pix_q.pix_blue} * {9'd0, pix_q.pix_blue};
  assign s_green = {9'd0, pix_q.pix_green} * {9'd0, pix_q.pix_green};
  assign s_red   = {9'd0, pix_q.pix_red} * {9'd0, pix_q.pix_red};
  // sum of squares needs 18 bits for a full-scale white pixel
  assign sq_sum  = {1'b0, s_blue} + {1'b0, s_green} + {1'b0, s_red};
  assign sq_in   = {sq_sum, 8'd0};
  assign den     = {1'b0, root_q} + 14'd16;

  always_comb begin
    case (ch_q)
      2'd0:    chv = pix_q.pix_blue;
      2'd1:    chv = pix_q.pix_green;
      default: chv = pix_q.pix_red;
    endcase
  end
  assign dividend = {chv, {(FracBits + 4){1'b0}}};

  // square-root step: root grows one bit per cycle, MSB first
  always_comb begin
    trial = {rem_q[25:0], 2'b00} | 28'd0;
    trial = {2'b00, rem_q} - ({14'd0, root_q, 1'b0} | 28'd0);
  end

  always_comb begin
    st_d   = st_q;
    rem_d  = rem_q;
    root_d = root_q;
    sqi_d  = sqi_q;
    ch_d   = ch_q;
    dvi_d  = dvi_q;
    quo_d  = quo_q;
    drem_d = drem_q;
    dshift = '0;
    case (st_q)
      FIdle: begin
        if (valid_i) begin
          st_d   = FSqrt;
          rem_d  = '0;
          root_d = '0;
          sqi_d  = 5'd12;
        end
      end
      FSqrt: begin
        root_d = root_q;
        st_d   = FSqrt;
        if (sqi_q == 5'd0) begin
          st_d  = FDiv;
          ch_d  = 2'd0;
          dvi_d = StepBits'(NumBits);
          drem_d = '0;
          quo_d = '0;
        end else begin
          sqi_d = sqi_q - 5'd1;
        end
      end
      FDiv: begin
        dshift = {drem_q[DenBits-1:0], dividend[dvi_q - StepBits'(1)]};
        if (dshift >= {1'b0, den}) begin
          drem_d = dshift - {1'b0, den};
          quo_d  = {quo_q[NumBits-2:0], 1'b1};
        end else begin
          drem_d = dshift;
          quo_d  = {quo_q[NumBits-2:0], 1'b0};
        end
        dvi_d = dvi_q - StepBits'(1);
        if (dvi_q == StepBits'(1)) begin
          drem_d = '0;
          dvi_d  = StepBits'(NumBits);
          if (ch_q == 2'd2) st_d = FDist;
          else ch_d = ch_q + 2'd1;
        end
      end
      FDist: st_d = FDone;
      FDone: if (!stall_i) st_d = FIdle;
      default: st_d = FIdle;
    endcase
  end

  // square root done as a separate restoring bit loop (13 result bits)
  logic [25:0] sq_rem_q, sq_rem_d;
  logic [12:0] sq_root_q, sq_root_d;
  logic [27:0] sq_try;
  logic [27:0] sq_cur;
  always_comb begin
    sq_cur = {sq_rem_q, sq_in[2*sqi_q[3:0] +: 2]};
    sq_try = {13'd0, sq_root_q, 2'b01};
    sq_rem_d  = sq_rem_q;
    sq_root_d = sq_root_q;
    if (st_q == FIdle) begin
      sq_rem_d  = '0;
      sq_root_d = '0;
    end else if (st_q == FSqrt) begin
      if (sq_cur >= sq_try) begin
        sq_rem_d  = 26'(sq_cur - sq_try);
        sq_root_d = {sq_root_q[11:0], 1'b1};
      end else begin
        sq_rem_d  = sq_cur[25:0];
        sq_root_d = {sq_root_q[11:0], 1'b0};
      end
    end
  end

  // distance
  assign db = ({1'b0, nb_q} >= (NumBits+1)'(ref_b_i)) ? {1'b0, nb_q} - (NumBits+1)'(ref_b_i)
            : (NumBits+1)'(ref_b_i) - {1'b0, nb_q};
  assign dg = ({1'b0, ng_q} >= (NumBits+1)'(ref_g_i)) ? {1'b0, ng_q} - (NumBits+1)'(ref_g_i)
            : (NumBits+1)'(ref_g_i) - {1'b0, ng_q};
  assign dr = ({1'b0, nr_q} >= (NumBits+1)'(ref_r_i)) ? {1'b0, nr_q} - (NumBits+1)'(ref_r_i)
            : (NumBits+1)'(ref_r_i) - {1'b0, nr_q};
  assign dist_sum = (2*NumBits+4)'(db * db) + (2*NumBits+4)'(dg * dg)
                  + (2*NumBits+4)'(dr * dr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= FIdle;
      sqi_q     <= '0;
      ch_q      <= '0;
      dvi_q     <= '0;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else begin
      st_q      <= st_d;
      sqi_q     <= sqi_d;
      ch_q      <= ch_d;
      dvi_q     <= dvi_d;
      sq_rem_q  <= sq_rem_d;
      sq_root_q <= sq_root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == FIdle && valid_i) pix_q <= data_i;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    drem_q <= drem_d;
    if (st_q == FSqrt && sqi_q == 5'd0) root_q <= sq_root_d;
    else root_q <= root_d;
    if (st_q == FDiv && dvi_q == StepBits'(1)) begin
      case (ch_q)
        2'd0:    nb_q <= quo_d;
        2'd1:    ng_q <= quo_d;
        default: nr_q <= quo_d;
      endcase
    end
    if (st_q == FDist) hit_q <= dist_sum < (2*NumBits+4)'({12'd0, tol_i} * {12'd0, tol_i});
  end

  assign stall_o = (st_q != FIdle);
  assign valid_o = (st_q == FDone);
  assign data_o  = pix_q;
  assign hit_o   = hit_q;

  logic unused;
  assign unused = ^{trial, rem_q};
endmodule

// File: hw/rtl/ckc_queue.sv
// Two-entry queue between classifier and accumulator.
module ckc_queue #(
  parameter int unsigned Width = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [Width-1:0] data_o
);
  logic [Width-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign stall_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];
  assign push    = valid_i && !stall_o;
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end
endmodule

// File: hw/rtl/ckc_back.sv
// Back: position counters, sums, and at frame end the centroid divides.
module ckc_back #(
  parameter int unsigned CoordBits = ckc_pkg::CoordBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  ckc_pkg::pix_in_t   pix_i,
  input  logic               hit_i,
  input  logic [12:0]        width_i,
  output logic               valid_o,
  input  logic               stall_i,
  output ckc_pkg::res_out_t  data_o
);
  import ckc_pkg::*;

  localparam int unsigned NumBits = SumBits + 4;
  localparam int unsigned StepBits = $clog2(NumBits + 1);

  bk_state_e st_q, st_d;
  logic [CoordBits-1:0] col_q, row_q;
  logic [SumBits-1:0]   scol_q, srow_q;
  logic [CntBits-1:0]   cnt_q, cnt_n;
  logic [SumBits-1:0]   scol_n, srow_n;
  res_out_t             res_q;
  logic                 sel_q;
  logic [StepBits-1:0]  dvi_q;
  logic [NumBits-1:0]   quo_q, dvd;
  logic [CntBits:0]     drem_q, dsh;
  logic [SumBits-1:0]   fs_col_q, fs_row_q;
  logic [CntBits-1:0]   fcnt_q;
  logic                 take, last_col;
  logic [15:0]          sat;

  function automatic logic [15:0] quo_sat(logic [NumBits-1:0] q, logic b);
    logic [NumBits-1:0] f;
    f = {q[NumBits-2:0], b};
    return (|f[NumBits-1:16]) ? 16'hFFFF : f[15:0];
  endfunction

  assign take   = (st_q == BkIdle) && valid_i;
  assign stall_o = (st_q != BkIdle);
  assign cnt_n  = cnt_q + CntBits'(hit_i);
  assign scol_n = hit_i ? scol_q + SumBits'(col_q) : scol_q;
  assign srow_n = hit_i ? srow_q + SumBits'(row_q) : srow_q;
  assign last_col = ({1'b0, 13'(col_q)} + 14'd1 >= {1'b0, width_i}) || (&col_q);
  assign dvd = {(sel_q ? fs_row_q : fs_col_q), 4'd0};
  assign dsh = {drem_q[CntBits-1:0], dvd[dvi_q - StepBits'(1)]};
  assign sat = (|quo_q[NumBits-1:16]) ? 16'hFFFF : quo_q[15:0];

  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle: if (take) st_d = (pix_i.end_of_frame && cnt_n != '0) ? BkDiv : BkOut;
      BkDiv:  if (dvi_q == StepBits'(1) && sel_q) st_d = BkOut;
      BkOut:  if (!stall_i) st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle;
      col_q <= '0; row_q <= '0;
      scol_q <= '0; srow_q <= '0; cnt_q <= '0;
      sel_q <= 1'b0; dvi_q <= '0;
    end else begin
      st_q <= st_d;
      if (take) begin
        sel_q <= 1'b0;
        dvi_q <= StepBits'(NumBits);
        if (pix_i.end_of_frame) begin
          col_q <= '0; row_q <= '0;
          scol_q <= '0; srow_q <= '0; cnt_q <= '0;
        end else begin
          scol_q <= scol_n; srow_q <= srow_n; cnt_q <= cnt_n;
          if (last_col) begin
            col_q <= '0;
            row_q <= row_q + CoordBits'(1);
          end else col_q <= col_q + CoordBits'(1);
        end
      end else if (st_q == BkDiv) begin
        if (dvi_q == StepBits'(1)) begin
          sel_q <= 1'b1;
          dvi_q <= StepBits'(NumBits);
        end else dvi_q <= dvi_q - StepBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fs_col_q <= scol_n; fs_row_q <= srow_n; fcnt_q <= cnt_n;
      drem_q <= '0; quo_q <= '0;
      res_q.out_blue      <= hit_i ? 8'd0 : pix_i.pix_blue;
      res_q.out_green     <= hit_i ? 8'd0 : pix_i.pix_green;
      res_q.out_red       <= hit_i ? 8'd255 : pix_i.pix_red;
      res_q.pixel_matched <= hit_i;
      res_q.frame_done    <= pix_i.end_of_frame;
      res_q.centroid_col  <= '0;
      res_q.centroid_row  <= '0;
      res_q.match_count   <= pix_i.end_of_frame ? cnt_n : '0;
      res_q.no_match      <= pix_i.end_of_frame && cnt_n == '0;
    end else if (st_q == BkDiv) begin
      // remainder restarts for the second divide after the last step
      if (dvi_q == StepBits'(1)) drem_q <= '0;
      else if (dsh >= {1'b0, fcnt_q}) drem_q <= dsh - {1'b0, fcnt_q};
      else drem_q <= dsh;
      quo_q <= {quo_q[NumBits-2:0], dsh >= {1'b0, fcnt_q}};
    end else if (st_q == BkOut) begin
    end
    if (st_q == BkDiv && dvi_q == StepBits'(1)) begin
      if (sel_q) res_q.centroid_row <= quo_sat(quo_q, dsh >= {1'b0, fcnt_q});
      else res_q.centroid_col <= quo_sat(quo_q, dsh >= {1'b0, fcnt_q});
    end
  end

  assign valid_o = (st_q == BkOut);
  assign data_o  = res_q;

  logic unused;
  assign unused = ^sat;
endmodule

// File: hw/rtl/color_key_centroid_top.sv
// Result path: the input transfer is accepted, then a 13-step square root, three
// 24-step divides and a distance step in the front, then the queue and back stage,
// plus, at frame end with matches, the two 40-step centroid divides.
// The front classifier takes no new pixel until it is through with the last; the queue
// lets the back accumulator overlap. Reset clears counters and sums and sets the
// configuration registers to their defaults; asynchronous, active low.
module color_key_centroid_top #(
  parameter int unsigned CoordBits = ckc_pkg::CoordBitsDef,
  parameter int unsigned FracBits  = ckc_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  ckc_pkg::pix_in_t    data_i,
  output logic                valid_o,
  input  logic                stall_i,
  output ckc_pkg::res_out_t   data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [12:0]         cfg_data_i
);
  import ckc_pkg::*;

  logic [11:0] tol_q;
  logic [12:0] rb_q, rg_q, rr_q, wid_q;
  logic        fv, fs, qv, qs, fhit, qhit;
  pix_in_t     fpix, qpix;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset; rb_q <= RefBReset; rg_q <= RefGReset;
      rr_q <= RefRReset; wid_q <= WidthReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTol:   tol_q <= cfg_data_i[11:0];
        RegRefB:  rb_q  <= cfg_data_i;
        RegRefG:  rg_q  <= cfg_data_i;
        RegRefR:  rr_q  <= cfg_data_i;
        RegWidth: wid_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ckc_front #(.FracBits(FracBits)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .data_i,
    .tol_i(tol_q), .ref_b_i(rb_q), .ref_g_i(rg_q), .ref_r_i(rr_q),
    .valid_o(fv), .stall_i(fs), .data_o(fpix), .hit_o(fhit)
  );

  ckc_queue #(.Width($bits(pix_in_t) + 1)) u_queue (
    .clk_i, .rst_ni, .valid_i(fv), .stall_o(fs), .data_i({fpix, fhit}),
    .valid_o(qv), .stall_i(qs), .data_o({qpix, qhit})
  );

  ckc_back #(.CoordBits(CoordBits)) u_back (
    .clk_i, .rst_ni, .valid_i(qv), .stall_o(qs), .pix_i(qpix), .hit_i(qhit),
    .width_i(wid_q), .valid_o, .stall_i, .data_o
  );
endmodule
